// ===== rtl/core/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int CELL_W  = 16;
    localparam int REQ_W   = 3;
    localparam int INDEX_W = 11;
    localparam int CROW_W  = 5;
    localparam int CCOL_W  = 7;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'd32;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd7;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUT     = 3'd0,
        REQ_BACK    = 3'd1,
        REQ_CLEAR   = 3'd2,
        REQ_RECOLOR = 3'd3,
        REQ_READ    = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        WB_FILL,
        WB_COPY,
        WB_RECOLOR
    } wb_kind_t;

    typedef struct packed {
        logic [CCOL_W-1:0] cursor_col;
        logic [CROW_W-1:0] cursor_row;
        logic [CELL_W-1:0] cell_value;
    } result_t;

endpackage

// ===== rtl/core/tcw_cell_mem.sv =====
`timescale 1ns / 1ps

module tcw_cell_mem
    import tcw_pkg::*;
#(
    parameter int DEPTH = DEF_ROWS * DEF_COLUMNS,
    parameter int AW    = $clog2(DEF_ROWS * DEF_COLUMNS)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [CELL_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/tcw_ctrl.sv =====
`timescale 1ns / 1ps

module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS,
    parameter int AW      = $clog2(DEF_ROWS * DEF_COLUMNS)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [COLOR_W-1:0] text_color,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [REQ_W-1:0]   in_req,
    input  logic [CHAR_W-1:0]  in_char,
    input  logic [INDEX_W-1:0] in_idx,
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res,
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output logic [CELL_W-1:0]  mem_wdata,
    output logic               mem_re,
    output logic [AW-1:0]      mem_raddr,
    input  logic [CELL_W-1:0]  mem_rdata
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam logic [RW-1:0] ROW_LAST     = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST     = CW'(COLUMNS - 1);
    localparam logic [AW-1:0] LAST_CELL    = AW'(CELLS - 1);
    localparam logic [AW-1:0] SCROLL_LIMIT = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] COLS_A       = AW'(COLUMNS);

    state_t               state_reg, state_next;
    req_t                 req_reg, req_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic [INDEX_W-1:0]   idx_reg, idx_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [RW-1:0]        row_reg, row_next;
    logic [CW-1:0]        col_reg, col_next;
    logic [CELL_W-1:0]    value_reg, value_next;
    logic [AW-1:0]        cnt_reg, cnt_next;
    wb_kind_t             mode_reg, mode_next;
    logic [COLOR_W-1:0]   fill_color_reg, fill_color_next;
    logic                 init_reg, init_next;
    logic                 wb_valid_reg, wb_valid_next;
    logic [AW-1:0]        wb_addr_reg, wb_addr_next;
    wb_kind_t             wb_kind_reg, wb_kind_next;

    logic                 is_newline;
    logic                 idx_in_range;
    logic [AW-1:0]        row_base;

    assign is_newline   = (char_reg == NEWLINE_CODE);
    assign idx_in_range = (32'(idx_reg) < 32'(CELLS));
    assign row_base     = AW'(AW'(row_reg) * COLS_A);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (req_reg)
                    REQ_PUT:
                    begin
                        if (is_newline && row_reg == ROW_LAST)
                        begin
                            state_next = ST_SWEEP;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    REQ_CLEAR, REQ_RECOLOR: state_next = ST_SWEEP;
                    REQ_READ:               state_next = ST_READ;
                    default:                state_next = ST_DONE;
                endcase
            end
            ST_READ:  state_next = ST_DONE;
            ST_SWEEP:
            begin
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = init_reg ? ST_IDLE : ST_DONE;
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs and memory ports
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        res_valid = (state_reg == ST_DONE);
        mem_we    = 1'b0;
        mem_waddr = wb_addr_reg;
        mem_wdata = {fill_color_reg, BLANK_CODE};
        mem_re    = 1'b0;
        mem_raddr = cnt_reg;
        if (wb_valid_reg)
        begin
            mem_we = 1'b1;
            case (wb_kind_reg)
                WB_COPY:    mem_wdata = mem_rdata;
                WB_RECOLOR: mem_wdata = {fill_color_reg, mem_rdata[CHAR_W-1:0]};
                default:    mem_wdata = {fill_color_reg, BLANK_CODE};
            endcase
        end
        else if (state_reg == ST_EXEC)
        begin
            mem_waddr = addr_reg;
            if (req_reg == REQ_PUT && !is_newline)
            begin
                mem_we    = 1'b1;
                mem_wdata = {text_color, char_reg};
            end
            else if (req_reg == REQ_BACK && col_reg != '0)
            begin
                mem_we    = 1'b1;
                mem_wdata = {text_color, BLANK_CODE};
            end
        end
        if (state_reg == ST_EXEC && req_reg == REQ_READ)
        begin
            mem_re    = idx_in_range;
            mem_raddr = AW'(idx_reg);
        end
        else if (state_reg == ST_SWEEP)
        begin
            if (mode_reg == WB_RECOLOR)
            begin
                mem_re = 1'b1;
            end
            else if (mode_reg == WB_COPY && cnt_reg < SCROLL_LIMIT)
            begin
                mem_re    = 1'b1;
                mem_raddr = AW'(cnt_reg + COLS_A);
            end
        end
    end

    // datapath
    always_comb
    begin
        req_next        = req_reg;
        char_next       = char_reg;
        idx_next        = idx_reg;
        addr_next       = addr_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        value_next      = value_reg;
        cnt_next        = cnt_reg;
        mode_next       = mode_reg;
        fill_color_next = fill_color_reg;
        init_next       = init_reg;
        wb_valid_next   = 1'b0;
        wb_addr_next    = cnt_reg;
        wb_kind_next    = mode_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = req_t'(in_req);
                    char_next  = in_char;
                    idx_next   = in_idx;
                    value_next = '0;
                    addr_next  = AW'(row_base + AW'(col_reg)
                                     - ((req_t'(in_req) == REQ_BACK) ? AW'(1) : AW'(0)));
                end
            end
            ST_EXEC:
            begin
                cnt_next        = '0;
                fill_color_next = text_color;
                case (req_reg)
                    REQ_PUT:
                    begin
                        if (is_newline)
                        begin
                            col_next = '0;
                            if (row_reg == ROW_LAST)
                            begin
                                mode_next = WB_COPY;
                            end
                            else
                            begin
                                row_next = row_reg + RW'(1);
                            end
                        end
                        else if (col_reg == COL_LAST)
                        begin
                            col_next = '0;
                            row_next = (row_reg == ROW_LAST) ? '0 : row_reg + RW'(1);
                        end
                        else
                        begin
                            col_next = col_reg + CW'(1);
                        end
                    end
                    REQ_BACK:
                    begin
                        if (col_reg != '0)
                        begin
                            col_next = col_reg - CW'(1);
                        end
                    end
                    REQ_CLEAR:
                    begin
                        mode_next = WB_FILL;
                        row_next  = '0;
                        col_next  = '0;
                    end
                    REQ_RECOLOR: mode_next = WB_RECOLOR;
                    default:     mode_next = mode_reg;
                endcase
            end
            ST_READ:
            begin
                if (idx_in_range)
                begin
                    value_next = mem_rdata;
                end
            end
            ST_SWEEP:
            begin
                wb_valid_next = 1'b1;
                if (mode_reg == WB_COPY && cnt_reg >= SCROLL_LIMIT)
                begin
                    wb_kind_next = WB_FILL;
                end
                if (cnt_reg != LAST_CELL)
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                init_next = 1'b0;
            end
            default:
            begin
                init_next = init_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            row_reg        <= '0;
            col_reg        <= '0;
            cnt_reg        <= '0;
            mode_reg       <= WB_FILL;
            fill_color_reg <= RESET_COLOR;
            init_reg       <= 1'b1;
            wb_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            cnt_reg        <= cnt_next;
            mode_reg       <= mode_next;
            fill_color_reg <= fill_color_next;
            init_reg       <= init_next;
            wb_valid_reg   <= wb_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        char_reg    <= char_next;
        idx_reg     <= idx_next;
        addr_reg    <= addr_next;
        value_reg   <= value_next;
        wb_addr_reg <= wb_addr_next;
        wb_kind_reg <= wb_kind_next;
    end

    assign res.cell_value = value_reg;
    assign res.cursor_row = CROW_W'(row_reg);
    assign res.cursor_col = CCOL_W'(col_reg);

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(row_reg) < 32'(ROWS)) && (32'(col_reg) < 32'(COLUMNS)))
        else $error("cursor out of range");

    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (32'(mem_waddr) < 32'(CELLS)))
        else $error("write beyond cell store");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted while busy");

    a_sweep_no_read_req: assert property (@(posedge clk) disable iff (!rst_n)
        wb_valid_reg |-> (state_reg == ST_SWEEP || state_reg == ST_DRAIN))
        else $error("write-back outside sweep");

endmodule

// ===== rtl/core/text_console_cell_writer_core.sv =====
`timescale 1ns / 1ps

// Text console cell store of ROWS x COLUMNS 16-bit cells (character in the low
// byte, attribute in the high byte) with a cursor. Requests arrive as s_tuser
// (request kind) and s_tdata; every request returns one word with the cell read
// (zero unless a read) and the cursor after the request. A cell read adds
// ST_READ after ST_EXEC, which other requests skip. Clear screen, recolor all
// and a scroll on the last row sweep the store through the single write port
// of the cell memory, one cell per cycle. After reset a clearing pass fills
// the store with blanks in color 7, during which s_tready stays low. text_color
// is written through cfg_valid/cfg_data; the user must write it only while no
// request is in flight, as the block itself does not enforce this.
module text_console_cell_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COLOR_W-1:0] cfg_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [23:0]        s_tdata,  // char_code, cell_index, zero fill
    input  logic [REQ_W-1:0]   s_tuser,  // req_type
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata   // cell_value, cursor_row, cursor_col
);

    localparam int AW = $clog2(ROWS * COLUMNS);

    logic [COLOR_W-1:0] text_color_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            out_data_reg;
    logic               res_valid;
    logic               res_ready;
    result_t            res;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [CELL_W-1:0]  mem_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= RESET_COLOR;
        end
        else if (cfg_valid)
        begin
            text_color_reg <= cfg_data;
        end
    end

    tcw_cell_mem #(
        .DEPTH (ROWS * COLUMNS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_color (text_color_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_req     (s_tuser),
        .in_char    (s_tdata[7:0]),
        .in_idx     (s_tdata[18:8]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    // output word register
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_data_reg};

endmodule

// ===== tb/tcw_screen_checker.sv =====
`timescale 1ns / 1ps

module tcw_screen_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [COLOR_W-1:0] cfg_data,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [23:0]        s_tdata,  // char_code, cell_index, zero fill
    input  logic [REQ_W-1:0]   s_tuser,  // req_type
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [31:0]        m_tdata,  // cell_value, cursor_row, cursor_col
    output int                 errors,
    output int                 pending
);

    localparam int CELLS = COLUMNS * ROWS;

    logic [CELL_W-1:0]  screen [0:CELLS-1];
    logic [CROW_W-1:0]  cur_row;
    logic [CCOL_W-1:0]  cur_col;
    logic [COLOR_W-1:0] color;
    result_t            expected_words[$];
    int                 error_count;

    function automatic void fill_screen(input logic [CELL_W-1:0] value);
        for (int i = 0; i < CELLS; i++)
        begin
            screen[i] = value;
        end
    endfunction

    function automatic result_t apply_request(input logic [REQ_W-1:0]   kind,
                                              input logic [CHAR_W-1:0]  ch,
                                              input logic [INDEX_W-1:0] idx);
        result_t word;
        int      pos;
        word.cell_value = '0;
        pos = int'(cur_row) * COLUMNS + int'(cur_col);
        case (req_t'(kind))
            REQ_PUT:
            begin
                if (ch == NEWLINE_CODE)
                begin
                    cur_col = '0;
                    if (int'(cur_row) + 1 >= ROWS)
                    begin
                        // scroll up one row, blank bottom row
                        for (int i = 0; i + COLUMNS < CELLS; i++)
                        begin
                            screen[i] = screen[i + COLUMNS];
                        end
                        for (int i = CELLS - COLUMNS; i < CELLS; i++)
                        begin
                            screen[i] = {color, BLANK_CODE};
                        end
                        cur_row = CROW_W'(ROWS - 1);
                    end
                    else
                    begin
                        cur_row = cur_row + CROW_W'(1);
                    end
                end
                else
                begin
                    screen[pos] = {color, ch};
                    cur_col = cur_col + CCOL_W'(1);
                    if (int'(cur_col) >= COLUMNS)
                    begin
                        cur_col = '0;
                        cur_row = cur_row + CROW_W'(1);
                        if (int'(cur_row) >= ROWS)
                        begin
                            cur_row = '0;
                        end
                    end
                end
            end
            REQ_BACK:
            begin
                if (cur_col != '0)
                begin
                    cur_col = cur_col - CCOL_W'(1);
                    screen[pos - 1] = {color, BLANK_CODE};
                end
            end
            REQ_CLEAR:
            begin
                fill_screen({color, BLANK_CODE});
                cur_row = '0;
                cur_col = '0;
            end
            REQ_RECOLOR:
            begin
                for (int i = 0; i < CELLS; i++)
                begin
                    screen[i][CELL_W-1:CHAR_W] = color;
                end
            end
            REQ_READ:
            begin
                if (int'(idx) < CELLS)
                begin
                    word.cell_value = screen[idx];
                end
            end
            default:
            begin
            end
        endcase
        word.cursor_row = cur_row;
        word.cursor_col = cur_col;
        return word;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_screen({RESET_COLOR, BLANK_CODE});
            cur_row = '0;
            cur_col = '0;
            color   = RESET_COLOR;
            expected_words.delete();
            error_count = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            result_t want;
            result_t got;
            if (cfg_valid && cfg_ready)
            begin
                color = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                expected_words.push_back(apply_request(s_tuser, s_tdata[7:0],
                                                       s_tdata[18:8]));
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[27:0];
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none actual %h",
                             $time, m_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got != want)
                    begin
                        error_count++;
                        if (got.cell_value != want.cell_value)
                        begin
                            $display("%0t: cell_value expected %h actual %h",
                                     $time, want.cell_value, got.cell_value);
                        end
                        if (got.cursor_row != want.cursor_row)
                        begin
                            $display("%0t: cursor_row expected %0d actual %0d",
                                     $time, want.cursor_row, got.cursor_row);
                        end
                        if (got.cursor_col != want.cursor_col)
                        begin
                            $display("%0t: cursor_col expected %0d actual %0d",
                                     $time, want.cursor_col, got.cursor_col);
                        end
                    end
                end
            end
            errors  <= error_count;
            pending <= expected_words.size();
        end
    end

endmodule

// ===== tb/tb_text_console_cell_writer_core.sv =====
`timescale 1ns / 1ps

module tb_text_console_cell_writer_core;

    import tcw_pkg::*;

    localparam int ITEM_TARGET = 1350;
    localparam int PHASES      = 6;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [COLOR_W-1:0] cfg_data  = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [23:0]        s_tdata   = '0;  // char_code, cell_index, zero fill
    logic [REQ_W-1:0]   s_tuser   = '0;  // req_type
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [31:0]        m_tdata;         // cell_value, cursor_row, cursor_col

    int errors;
    int pending;
    int sent_count = 0;
    int stall_left = 0;
    int rx_roll;
    bit steady     = 1'b0;

    text_console_cell_writer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    tcw_screen_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (steady)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 75)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready   <= 1'b0;
                stall_left <= (rx_roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CHAR_W-1:0] text_char();
        logic [CHAR_W-1:0] ch;
        ch = CHAR_W'($urandom_range(0, 255));
        if (ch == NEWLINE_CODE)
        begin
            ch = BLANK_CODE;
        end
        return ch;
    endfunction

    task automatic send_req(input logic [REQ_W-1:0]   kind,
                            input logic [CHAR_W-1:0]  ch,
                            input logic [INDEX_W-1:0] idx);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'd0, idx, ch};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        if (kind <= REQ_READ)
        begin
            sent_count++;
        end
    endtask

    task automatic write_color(input logic [COLOR_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_burst();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            // a line of text, sometimes ended by a newline
            n = $urandom_range(1, 90);
            repeat (n) send_req(REQ_PUT, text_char(), INDEX_W'($urandom));
            if ($urandom_range(0, 1) == 1)
            begin
                send_req(REQ_PUT, NEWLINE_CODE, INDEX_W'($urandom));
            end
        end
        else if (r < 38)
        begin
            n = $urandom_range(1, 8);
            repeat (n) send_req(REQ_PUT, NEWLINE_CODE, INDEX_W'($urandom));
        end
        else if (r < 56)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    send_req(REQ_READ, CHAR_W'($urandom), INDEX_W'($urandom_range(0, 2047)));
                end
                else
                begin
                    send_req(REQ_READ, CHAR_W'($urandom), INDEX_W'($urandom_range(0, 1999)));
                end
            end
        end
        else if (r < 68)
        begin
            n = $urandom_range(1, 12);
            repeat (n) send_req(REQ_BACK, CHAR_W'($urandom), INDEX_W'($urandom));
        end
        else if (r < 73)
        begin
            send_req(REQ_CLEAR, CHAR_W'($urandom), INDEX_W'($urandom));
        end
        else if (r < 79)
        begin
            send_req(REQ_RECOLOR, CHAR_W'($urandom), INDEX_W'($urandom));
        end
        else if (r < 85)
        begin
            // walk to the last row and type up to or past its end
            send_req(REQ_CLEAR, CHAR_W'($urandom), INDEX_W'($urandom));
            repeat (DEF_ROWS - 1) send_req(REQ_PUT, NEWLINE_CODE, INDEX_W'($urandom));
            n = $urandom_range(DEF_COLUMNS - 2, DEF_COLUMNS + 10);
            repeat (n) send_req(REQ_PUT, text_char(), INDEX_W'($urandom));
            send_req(REQ_READ, CHAR_W'($urandom),
                     INDEX_W'((DEF_ROWS - 1) * DEF_COLUMNS + $urandom_range(0, DEF_COLUMNS - 1)));
        end
        else if (r < 90)
        begin
            n = $urandom_range(1, 3);
            repeat (n) send_req(REQ_W'($urandom_range(5, 7)), CHAR_W'($urandom),
                                INDEX_W'($urandom));
        end
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_req(REQ_W'($urandom_range(0, 7)), CHAR_W'($urandom),
                                INDEX_W'($urandom));
        end
    endtask

    initial
    begin
        logic [COLOR_W-1:0] phase_colors [PHASES];
        phase_colors[0] = 8'h00;
        phase_colors[1] = 8'hFF;
        phase_colors[2] = COLOR_W'($urandom);
        phase_colors[3] = 8'h5A;
        phase_colors[4] = COLOR_W'($urandom);
        phase_colors[5] = RESET_COLOR;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed part
        send_req(REQ_READ, 8'h00, 11'd0);
        send_req(REQ_READ, 8'hFF, 11'd1999);
        send_req(REQ_READ, 8'h00, 11'd2047);
        send_req(REQ_BACK, 8'h00, 11'd0);
        send_req(REQ_PUT, 8'h00, 11'd2047);
        send_req(REQ_PUT, 8'hFF, 11'd0);
        send_req(REQ_PUT, 8'h41, 11'd0);
        send_req(REQ_BACK, 8'h00, 11'd0);
        send_req(REQ_READ, 8'h00, 11'd1);
        send_req(REQ_READ, 8'h00, 11'd2);
        send_req(REQ_PUT, NEWLINE_CODE, 11'd0);
        send_req(REQ_RECOLOR, 8'h00, 11'd0);
        send_req(REQ_READ, 8'h00, 11'd0);
        send_req(3'd5, 8'hFF, 11'd2047);
        send_req(3'd6, 8'h00, 11'd0);
        send_req(3'd7, 8'hFF, 11'd2047);
        send_req(REQ_CLEAR, 8'h00, 11'd0);
        send_req(REQ_READ, 8'h00, 11'd1);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_color(phase_colors[phase]);
            if (phase == 1)
            begin
                send_req(REQ_PUT, 8'h5A, 11'd0);
                send_req(REQ_READ, 8'h00, 11'd0);
                send_req(REQ_RECOLOR, 8'h00, 11'd0);
                send_req(REQ_READ, 8'h00, 11'd1);
            end
            while (sent_count < (phase + 1) * ITEM_TARGET / PHASES + 18)
            begin
                steady = (phase == 2) || ($urandom_range(0, 99) < 10);
                run_burst();
            end
        end

        s_tvalid <= 1'b0;
        steady = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DEF_ROWS * DEF_COLUMNS + 10) @(negedge clk);

        if (errors == 0 && pending == 0)
        begin
            $display("text_console_cell_writer_core regression: pass");
        end
        else
        begin
            $display("text_console_cell_writer_core regression: fail");
        end
        $finish;
    end

    initial
    begin
        #300_000_000;
        $display("text_console_cell_writer_core regression: fail");
        $finish;
    end

endmodule
